@@ rtl/skpi_pkg.sv @@
// shared types and constants for the sorted key position index
package skpi_pkg;

	localparam int KEY_W   = 32;
	localparam int POS_W   = 31;
	localparam int SLOT_W  = 10;
	localparam int COUNT_W = 11;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_BAD_SLOT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_COMPARE,
		S_UPDATE
	} state_t;

	typedef struct packed {
		cmd_t                     command;
		logic signed [KEY_W-1:0]  key_value;
		logic [POS_W-1:0]         row_position;
		logic                     renumber;
		logic [SLOT_W-1:0]        remove_slot;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] entry_count;
		status_t            status;
	} rsp_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                     cmp_en;
		logic                     upd_en;
		cmd_t                     command;
		logic signed [KEY_W-1:0]  key;
		logic [POS_W-1:0]         pos;
		logic                     renumber;
		logic [SLOT_W-1:0]        rem_slot;
	} ctl_t;

endpackage

@@ rtl/skpi_if.sv @@
// valid/ready channels for requests and results
interface skpi_req_if import skpi_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface skpi_rsp_if import skpi_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

@@ rtl/skpi_cell.sv @@
// one table slot: holds a key and row position, shifts with its neighbors
module skpi_cell import skpi_pkg::*; #(
	parameter int INDEX = 0,
	parameter int CNT_W = 11
) (
	input  logic                    clk,
	input  ctl_t                    ctl,
	input  logic [CNT_W-1:0]        count,
	input  logic signed [KEY_W-1:0] prev_key,
	input  logic [POS_W-1:0]        prev_pos,
	input  logic                    prev_less,
	input  logic signed [KEY_W-1:0] next_key,
	input  logic [POS_W-1:0]        next_pos,
	output logic signed [KEY_W-1:0] key,
	output logic [POS_W-1:0]        pos,
	output logic                    less
);

	logic signed [KEY_W-1:0] key_q;
	logic [POS_W-1:0]        pos_q;
	logic                    less_s1;
	logic signed [KEY_W-1:0] key_d;
	logic [POS_W-1:0]        pos_d;
	logic [POS_W-1:0]        src_pos;
	logic                    valid;
	logic                    at_or_above;

	assign valid       = CNT_W'(INDEX) < count;
	assign at_or_above = {{CNT_W{1'b0}}, ctl.rem_slot} <= (CNT_W + SLOT_W)'(INDEX);

	always_comb begin
		key_d   = key_q;
		pos_d   = pos_q;
		src_pos = at_or_above ? next_pos : pos_q;
		case (ctl.command)
			CMD_INSERT: begin
				if (!less_s1) begin
					if (prev_less) begin
						// this is the lower-bound slot
						key_d = ctl.key;
						pos_d = ctl.pos;
					end else begin
						key_d = prev_key;
						pos_d = ctl.renumber ? prev_pos + POS_W'(1) : prev_pos;
					end
				end
			end
			CMD_REMOVE: begin
				key_d = at_or_above ? next_key : key_q;
				pos_d = (src_pos > {{(POS_W - SLOT_W){1'b0}}, ctl.rem_slot})
					? src_pos - POS_W'(1) : src_pos;
			end
			default: begin
				key_d = key_q;
				pos_d = pos_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			less_s1 <= valid && (key_q < ctl.key);
		end
		if (ctl.upd_en) begin
			key_q <= key_d;
			pos_q <= pos_d;
		end
	end

	assign key  = key_q;
	assign pos  = pos_q;
	assign less = less_s1;

endmodule

@@ rtl/skpi_encode.sv @@
// one-hot insert boundary to slot index
module skpi_encode #(
	parameter int DEPTH = 1024,
	parameter int IDX_W = 10
) (
	input  logic [DEPTH-1:0] onehot,
	output logic [IDX_W-1:0] index
);

	always_comb begin
		index = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (onehot[i]) begin
				index = index | IDX_W'(i);
			end
		end
	end

endmodule

@@ rtl/sorted_key_position_index.sv @@
// sorted key / row position index: top level with controller and cell row
// a request passes through the compare and update states before its result is registered
// each request takes a compare step, then a shift step of the cell row
// the next request is taken in the shift cycle when the result register is free
// reset clears the entry count and the result valid flag; table contents stay undefined
module sorted_key_position_index import skpi_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	skpi_req_if.sink         req,
	skpi_rsp_if.source       rsp
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	state_t             state_q;
	state_t             state_d;
	req_t               req_q;
	logic [CNT_W-1:0]   count_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	ctl_t               ctl;
	logic               out_free;
	logic               ins_ok;
	logic               rem_ok;
	logic               op_ok;
	logic               finish;
	logic [CNT_W-1:0]   count_d;
	logic [IDX_W-1:0]   ins_slot;
	logic [SLOT_W-1:0]  slot_d;
	logic [SLOT_W+IDX_W-1:0]  ins_slot_wide;
	logic [COUNT_W+CNT_W-1:0] count_wide;

	logic signed [KEY_W-1:0] cell_key [DEPTH];
	logic [POS_W-1:0]        cell_pos [DEPTH];
	logic [DEPTH-1:0]        less;
	logic [DEPTH-1:0]        prev_less;
	logic [DEPTH-1:0]        boundary;

	assign out_free = !rsp_valid_q || rsp.ready;
	assign ins_ok   = count_q < CNT_W'(DEPTH);
	assign rem_ok   = {{CNT_W{1'b0}}, req_q.remove_slot} < {{SLOT_W{1'b0}}, count_q};
	assign op_ok    = (req_q.command == CMD_INSERT) ? ins_ok : rem_ok;
	assign finish   = (state_q == S_UPDATE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = S_COMPARE;
				end
			end
			S_COMPARE: begin
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				req.ready = out_free;
				if (out_free) begin
					state_d = req.valid ? S_COMPARE : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_q <= req.payload;
		end
	end

	assign ctl.cmp_en   = (state_q == S_COMPARE);
	assign ctl.upd_en   = finish && op_ok;
	assign ctl.command  = req_q.command;
	assign ctl.key      = req_q.key_value;
	assign ctl.pos      = req_q.row_position;
	assign ctl.renumber = req_q.renumber;
	assign ctl.rem_slot = req_q.remove_slot;

	// the cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign prev_less[i] = 1'b1;
		end else begin : g_rest
			assign prev_less[i] = less[i-1];
		end
		assign boundary[i] = !less[i] && prev_less[i];

		skpi_cell #(
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.count     (count_q),
			.prev_key  ((i == 0) ? cell_key[i] : cell_key[(i == 0) ? 0 : i-1]),
			.prev_pos  ((i == 0) ? cell_pos[i] : cell_pos[(i == 0) ? 0 : i-1]),
			.prev_less (prev_less[i]),
			.next_key  (cell_key[(i == DEPTH-1) ? i : i+1]),
			.next_pos  (cell_pos[(i == DEPTH-1) ? i : i+1]),
			.key       (cell_key[i]),
			.pos       (cell_pos[i]),
			.less      (less[i])
		);
	end

	skpi_encode #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_encode (
		.onehot (boundary),
		.index  (ins_slot)
	);

	assign ins_slot_wide = {{SLOT_W{1'b0}}, ins_slot};

	always_comb begin
		count_d = count_q;
		slot_d  = '0;
		if (op_ok) begin
			if (req_q.command == CMD_INSERT) begin
				count_d = count_q + CNT_W'(1);
				slot_d  = ins_slot_wide[SLOT_W-1:0];
			end else begin
				count_d = count_q - CNT_W'(1);
				slot_d  = req_q.remove_slot;
			end
		end
	end

	assign count_wide = {{COUNT_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_q.slot        <= slot_d;
			rsp_q.entry_count <= count_wide[COUNT_W-1:0];
			if (op_ok) begin
				rsp_q.status <= STAT_OK;
			end else if (req_q.command == CMD_INSERT) begin
				rsp_q.status <= STAT_FULL;
			end else begin
				rsp_q.status <= STAT_BAD_SLOT;
			end
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// sorted table: the insert boundary is unique whenever there is room
	a_one_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPDATE && req_q.command == CMD_INSERT && ins_ok) |-> $onehot(boundary))
		else $error("insert boundary not unique");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.upd_en |=> (count_q != $past(count_q)))
		else $error("table changed without count change");

	a_no_update_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |-> !ctl.upd_en)
		else $error("cells updated while result held");

endmodule

@@ dv/sorted_key_position_index_test.sv @@
// self-checking testbench for the sorted key position index
module sorted_key_position_index_test import skpi_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 1024;

	// mirrors the sorted table and predicts one result per accepted request
	class index_scoreboard;
		bit signed [KEY_W-1:0] key_col [TABLE_DEPTH];
		bit [POS_W-1:0]        pos_col [TABLE_DEPTH];
		int unsigned           entries;
		rsp_t                  awaited [$];
		int unsigned           errors, accepted, checked;
		int unsigned           inserts, renumbered, removes, full_hits, bad_slots, peak;

		function void note_request(req_t r);
			rsp_t exp;
			int unsigned at;
			exp.slot = '0;
			exp.status = STAT_OK;
			accepted++;
			if (r.command == CMD_INSERT) begin
				if (entries >= TABLE_DEPTH) begin
					exp.status = STAT_FULL;
					full_hits++;
				end else begin
					// lower bound: first slot whose key is not below the new one
					at = 0;
					while (at < entries && key_col[at] < r.key_value)
						at++;
					for (int i = entries; i > at; i--) begin
						key_col[i] = key_col[i-1];
						pos_col[i] = pos_col[i-1];
					end
					key_col[at] = r.key_value;
					pos_col[at] = r.row_position;
					entries++;
					if (r.renumber) begin
						for (int i = at + 1; i < entries; i++)
							pos_col[i] = pos_col[i] + 1'b1;
						renumbered++;
					end
					exp.slot = SLOT_W'(at);
					inserts++;
					if (entries > peak)
						peak = entries;
				end
			end else begin
				at = r.remove_slot;
				if (at >= entries) begin
					exp.status = STAT_BAD_SLOT;
					bad_slots++;
				end else begin
					for (int i = at; i + 1 < entries; i++) begin
						key_col[i] = key_col[i+1];
						pos_col[i] = pos_col[i+1];
					end
					entries--;
					for (int i = 0; i < entries; i++)
						if (pos_col[i] > at)
							pos_col[i] = pos_col[i] - 1'b1;
					exp.slot = SLOT_W'(at);
					removes++;
				end
			end
			exp.entry_count = COUNT_W'(entries);
			awaited.push_back(exp);
		endfunction

		function void check_result(rsp_t got);
			rsp_t exp;
			bit bad;
			bad = 0;
			if (awaited.size() == 0) begin
				$error("result with no request pending: slot %0d count %0d status %0d",
					got.slot, got.entry_count, got.status);
				errors++;
				return;
			end
			exp = awaited.pop_front();
			checked++;
			if (got.slot !== exp.slot) begin
				$error("slot: expected %0d, got %0d", exp.slot, got.slot);
				bad = 1;
			end
			if (got.entry_count !== exp.entry_count) begin
				$error("entry_count: expected %0d, got %0d", exp.entry_count, got.entry_count);
				bad = 1;
			end
			if (got.status !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, got.status);
				bad = 1;
			end
			if (bad)
				errors++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	skpi_req_if req_ch ();
	skpi_rsp_if rsp_ch ();

	sorted_key_position_index #(.DEPTH(TABLE_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	index_scoreboard sb = new();
	int burst_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_result(rsp_ch.payload);
	end

	// receiver: changing stall patterns plus one long hold-off to back up the block
	initial begin
		int mode, mode_left;
		bit held;
		mode = 0;
		mode_left = 0;
		held = 0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held && sb.accepted >= 300) begin
				held = 1;
				rsp_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 150);
				end
				mode_left--;
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom);
					2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	function automatic req_t make_insert(logic signed [KEY_W-1:0] k, logic [POS_W-1:0] p,
		logic rn);
		req_t r;
		r.command = CMD_INSERT;
		r.key_value = k;
		r.row_position = p;
		r.renumber = rn;
		r.remove_slot = SLOT_W'($urandom);
		return r;
	endfunction

	function automatic req_t make_remove(logic [SLOT_W-1:0] s);
		req_t r;
		r.command = CMD_REMOVE;
		r.key_value = $urandom;
		r.row_position = POS_W'($urandom);
		r.renumber = 1'($urandom);
		r.remove_slot = s;
		return r;
	endfunction

	function automatic logic signed [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $urandom;
			5, 6, 7: return $signed($urandom_range(0, 16)) - 8;
			8: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 0;
					default: return -1;
				endcase
			end
			// duplicate of a stored key
			default: return (sb.entries != 0) ? sb.key_col[$urandom_range(0, sb.entries - 1)] : 0;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		case ($urandom_range(0, 7))
			0, 1, 2, 3, 4: return POS_W'($urandom);
			5, 6: return POS_W'($urandom_range(0, 20));
			// near the top so renumbering wraps
			default: return ~POS_W'($urandom_range(0, 3));
		endcase
	endfunction

	function automatic req_t random_insert();
		return make_insert(pick_key(), pick_position(), 1'($urandom));
	endfunction

	function automatic req_t random_remove();
		if (sb.entries != 0 && $urandom_range(0, 4) != 0)
			return make_remove(SLOT_W'($urandom_range(0, sb.entries - 1)));
		return make_remove(SLOT_W'($urandom_range(0, 1023)));
	endfunction

	// sender works in bursts with random gaps
	task automatic offer(input req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.payload <= r;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(r);
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: empty removes, key extremes, equal keys, renumber wrap, bad slots
		offer(make_remove(10'd0));
		offer(make_remove(10'd1023));
		offer(make_insert(0, 31'd5, 1'b0));
		offer(make_insert(32'h7fff_ffff, 31'h7fff_ffff, 1'b0));
		offer(make_insert(32'h8000_0000, 31'd0, 1'b1));
		offer(make_insert(0, 31'd1, 1'b1));
		offer(make_insert(0, 31'd2, 1'b0));
		offer(make_insert(-1, 31'd3, 1'b0));
		offer(make_remove(10'd1));
		offer(make_remove(10'd4));
		offer(make_remove(SLOT_W'(sb.entries)));
		offer(make_remove(10'd1023));
		offer(make_insert(32'h7fff_ffff, 31'd100, 1'b1));
		offer(make_insert(32'h8000_0000, 31'h7fff_ffff, 1'b1));
		offer(make_insert(-1, 31'h7fff_fffe, 1'b1));
		offer(make_remove(SLOT_W'(sb.entries - 1)));
		offer(make_remove(10'd0));
		offer(make_insert(0, 31'd0, 1'b1));
		offer(make_remove(10'd2));
		wait_idle();

		// fill the table until it is full
		while (sb.entries < TABLE_DEPTH) begin
			if ($urandom_range(0, 19) != 0)
				offer(random_insert());
			else
				offer(random_remove());
		end
		repeat (6) offer(random_insert());
		offer(make_remove(10'd1023));
		offer(make_remove(10'd0));
		repeat (3) offer(random_insert());
		wait_idle();

		// mixed traffic on a well-populated table
		repeat (650) begin
			if ($urandom_range(0, 19) < 9)
				offer(random_insert());
			else
				offer(random_remove());
		end

		wait_idle();
		repeat (10) @(posedge clk);
		$display("%0d requests, %0d results: %0d inserts (%0d renumbered), %0d removes",
			sb.accepted, sb.checked, sb.inserts, sb.renumbered, sb.removes);
		$display("%0d full-table inserts, %0d bad-slot removes, peak of %0d entries",
			sb.full_hits, sb.bad_slots, sb.peak);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/skpi_pkg.sv
rtl/skpi_if.sv
rtl/skpi_cell.sv
rtl/skpi_encode.sv
rtl/sorted_key_position_index.sv
dv/sorted_key_position_index_test.sv
